@@ design/hee_pkg.sv @@
// Shared types, codes and helpers for the HTML entity escape stream.
// Used by hee_encode and html_entity_escape_stream; no dependencies.
package hee_pkg;

    localparam int SEQ_MAX = 8;

    // Held UTF-8 state.
    localparam logic [1:0] PEND_NONE   = 2'd0;
    localparam logic [1:0] PEND_LEAD   = 2'd1;
    localparam logic [1:0] PEND_SECOND = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    localparam logic [7:0] LEAD_MIN      = 8'd194;
    localparam logic [7:0] LEAD_3B_MIN   = 8'd224;
    localparam logic [7:0] LEAD_2DIG_MAX = 8'd195;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] second;
        logic [1:0] pend;
    } hee_state_t;

    // Up to eight output characters produced by one request.
    typedef struct packed {
        logic [SEQ_MAX-1:0][7:0] chars;
        logic [3:0]              count;
    } seq_t;

    function automatic seq_t seq_put(seq_t s, logic [7:0] ch);
        seq_t r;
        r = s;
        if (s.count < 4'(SEQ_MAX)) begin
            r.chars[s.count[2:0]] = ch;
            r.count = s.count + 4'd1;
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_digit(logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = CH_0 + {4'b0, d};
        end else begin
            r = CH_UPPER_A + {4'b0, d - 4'd10};
        end
        return r;
    endfunction

endpackage

@@ design/hee_encode.sv @@
// Combinational encoder: one source byte and the held state give the
// escaped character run and the next held state. Depends on hee_pkg.
module hee_encode import hee_pkg::*; (
    input  in_item_t   item,
    input  logic       unicode_mode,
    input  hee_state_t cur,
    output seq_t       seq,
    output hee_state_t nxt
);

    logic [7:0]  b;
    logic [4:0]  lead_2b;
    logic [11:0] val_2b;
    logic [3:0]  lead_3b;
    logic [15:0] val_3b;
    logic [15:0] ref_val;
    logic [2:0]  ref_digits;
    logic        do_ref;
    logic        do_plain;
    logic        is_cont;

    assign b       = item.in_byte;
    assign is_cont = b inside {[8'd128:8'd191]};

    // Two-byte value: (lead - 194) * 64 + continuation byte.
    assign lead_2b = 5'(cur.lead - LEAD_MIN);
    assign val_2b  = {1'b0, lead_2b, 6'b0} + {4'b0, b};

    // Three-byte value, kept to the low four nibbles that get printed.
    assign lead_3b = 4'(cur.lead - LEAD_3B_MIN);
    assign val_3b  = {lead_3b, 12'b0} + {4'b0, cur.second[5:0], 6'b0}
                   + ({8'b0, b} - 16'd128);

    always_comb begin
        seq_t s;
        s          = '0;
        nxt        = cur;
        do_ref     = 1'b0;
        do_plain   = 1'b0;
        ref_val    = '0;
        ref_digits = 3'd2;

        if (item.is_end) begin
            if (cur.pend == PEND_LEAD || cur.pend == PEND_SECOND) begin
                s = seq_put(s, CH_QMARK);
            end
            s   = seq_put(s, CH_NUL);
            nxt = '0;
        end else begin
            case (cur.pend)
                PEND_LEAD: begin
                    if (is_cont) begin
                        if (cur.lead < LEAD_3B_MIN) begin
                            do_ref     = 1'b1;
                            ref_val    = {4'b0, val_2b};
                            ref_digits = (cur.lead > LEAD_2DIG_MAX) ? 3'd3 : 3'd2;
                            nxt.pend   = PEND_NONE;
                        end else begin
                            nxt.second = b;
                            nxt.pend   = PEND_SECOND;
                        end
                    end else begin
                        // A broken sequence gives '?' and the byte is then
                        // treated as fresh input.
                        s        = seq_put(s, CH_QMARK);
                        nxt.pend = PEND_NONE;
                        do_plain = 1'b1;
                    end
                end
                PEND_SECOND: begin
                    do_ref     = 1'b1;
                    ref_val    = val_3b;
                    ref_digits = (cur.lead > LEAD_3B_MIN) ? 3'd4 : 3'd3;
                    nxt.pend   = PEND_NONE;
                end
                default: begin
                    nxt.pend = PEND_NONE;
                    do_plain = 1'b1;
                end
            endcase

            if (do_ref) begin
                s = seq_put(s, CH_AMP);
                s = seq_put(s, CH_HASH);
                s = seq_put(s, CH_X);
                for (int k = 3; k >= 0; k--) begin
                    if (3'(k) < ref_digits) begin
                        s = seq_put(s, hex_digit(ref_val[4*k +: 4]));
                    end
                end
                s = seq_put(s, CH_SEMI);
            end

            if (do_plain) begin
                if (b == CH_GT) begin
                    s = seq_put(s, CH_AMP);
                    s = seq_put(s, CH_G);
                    s = seq_put(s, CH_T);
                    s = seq_put(s, CH_SEMI);
                end else if (b == CH_LT) begin
                    s = seq_put(s, CH_AMP);
                    s = seq_put(s, CH_L);
                    s = seq_put(s, CH_T);
                    s = seq_put(s, CH_SEMI);
                end else if (b == CH_AMP) begin
                    s = seq_put(s, CH_AMP);
                    s = seq_put(s, CH_A);
                    s = seq_put(s, CH_M);
                    s = seq_put(s, CH_P);
                    s = seq_put(s, CH_SEMI);
                end else if (b == CH_QUOT) begin
                    s = seq_put(s, CH_AMP);
                    s = seq_put(s, CH_Q);
                    s = seq_put(s, CH_U);
                    s = seq_put(s, CH_O);
                    s = seq_put(s, CH_T);
                    s = seq_put(s, CH_SEMI);
                end else if (unicode_mode && b > 8'd193) begin
                    nxt.lead = b;
                    nxt.pend = PEND_LEAD;
                end else begin
                    s = seq_put(s, b);
                end
            end
        end
        seq = s;
    end

endmodule

@@ design/html_entity_escape_stream.sv @@
// Top level of the HTML entity escape stream: held UTF-8 state, the
// result run register and the output serializer. Depends on hee_pkg, hee_encode.
//
//   channel | ports                          | payload
//   --------+--------------------------------+------------------------------
//   input   | s_valid s_ready s_data         | in_item_t  (in_byte, is_end)
//   output  | m_valid m_ready m_data         | out_item_t (out_char, run_last)
//   config  | cfg_wr_en cfg_wr_data          | unicode_mode
//
// A request is encoded in the cycle it is accepted; its run of 0 to 8
// characters goes out one per cycle while m_ready is high, from the run register.
// The next request is accepted in the cycle the last character of a run is taken.
// Requests that give no result (a held lead byte) are accepted every cycle.
// Reset (aresetn low, synchronous) empties the run register, clears the held
// state and sets unicode_mode to 1.
module html_entity_escape_stream import hee_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data
);

    logic       mode_reg;
    hee_state_t state_reg;
    hee_state_t state_next;
    seq_t       seq_next;
    logic [SEQ_MAX-1:0][7:0] chars_reg;
    logic [3:0] count_reg;
    logic [2:0] idx_reg;
    logic       is_last;
    logic       s_fire;

    hee_encode u_encode (
        .item         (s_data),
        .unicode_mode (mode_reg),
        .cur          (state_reg),
        .seq          (seq_next),
        .nxt          (state_next)
    );

    assign m_valid = (count_reg != 4'd0);
    assign is_last = ({1'b0, idx_reg} == count_reg - 4'd1);
    assign s_ready = !m_valid || (m_ready && is_last);
    assign s_fire  = s_valid && s_ready;

    assign m_data.out_char = chars_reg[idx_reg];
    assign m_data.run_last = is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b1;
            state_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                state_reg <= state_next;
                count_reg <= seq_next.count;
                idx_reg   <= '0;
            end else if (m_valid && m_ready) begin
                if (is_last) begin
                    count_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            chars_reg <= seq_next.chars;
        end
    end

    // The read pointer always lies inside the stored run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, idx_reg} < count_reg))
        else $error("run pointer beyond run length");

    // A stalled output blocks new requests.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("request accepted while output stalled");

    // A taken character that is not the last keeps the run going.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !is_last) |=> (m_valid && idx_reg == $past(idx_reg) + 3'd1))
        else $error("run advanced incorrectly");

    // The held-state counter never reaches its unused code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pend != 2'd3)
        else $error("held state counter corrupted");

    // An end marker always leaves nothing held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.is_end) |=> (state_reg.pend == PEND_NONE))
        else $error("held state survived end marker");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for html_entity_escape_stream: a directed table, then random
// text phases under several unicode_mode settings. Depends on hee_pkg and the design.
module tb;
    import hee_pkg::*;

    localparam logic [7:0] CONT_MIN       = 8'd128;
    localparam logic [7:0] CONT_MAX       = 8'd191;
    localparam int         RUN_MAX        = SEQ_MAX;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         DRAIN_CYCLES   = 16;
    localparam int         LONG_HOLD      = 80;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASE_ITEMS    = 60;

    typedef enum logic {ROW_ITEM, ROW_MODE} row_kind_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    logic      cfg_wr_en;
    logic      cfg_wr_data;

    html_entity_escape_stream u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Predicted escaper state and configuration.
    logic       uni_mode;
    logic [7:0] lead_byte;
    logic [7:0] second_byte;
    logic [1:0] pend_state;

    // Characters produced by the request being predicted.
    logic [7:0] run_buf [0:RUN_MAX-1];
    int         run_len;

    out_item_t  expected_chars [$];
    out_item_t  want;

    // Directed table, one entry per row across the parallel queues.
    row_kind_t  row_kind  [$];
    in_item_t   row_item  [$];
    logic       row_typed [$];
    string      row_text  [$];
    logic       row_mode  [$];

    int errors = 0;
    int items_sent;
    int chars_checked = 0;
    int refs_predicted;
    int mode_writes;
    int burst_left;
    logic hold_request;

    function automatic logic [7:0] nibble_char(input logic [3:0] d);
        string digits;
        digits = "0123456789ABCDEF";
        return digits[d];
    endfunction

    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    task automatic emit(input logic [7:0] ch);
        if (run_len < RUN_MAX) begin
            run_buf[run_len] = ch;
            run_len++;
        end
    endtask

    task automatic emit_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) emit(s[i]);
    endtask

    task automatic emit_ref(input logic [31:0] val, input int ndig);
        int k;
        emit(CH_AMP);
        emit(CH_HASH);
        emit(CH_X);
        for (k = ndig - 1; k >= 0; k--) emit(nibble_char(4'(val >> (4 * k))));
        emit(CH_SEMI);
        refs_predicted++;
    endtask

    task automatic plain_byte(input logic [7:0] b);
        case (b)
            CH_GT:   emit_text("&gt;");
            CH_LT:   emit_text("&lt;");
            CH_AMP:  emit_text("&amp;");
            CH_QUOT: emit_text("&quot;");
            default: begin
                if (uni_mode && b >= LEAD_MIN) begin
                    lead_byte  = b;
                    pend_state = PEND_LEAD;
                end else begin
                    emit(b);
                end
            end
        endcase
    endtask

    // Works out the output run of one request and advances the predicted state.
    task automatic predict_escape(input in_item_t it);
        logic [7:0]  b;
        logic [31:0] v;
        b = it.in_byte;
        run_len = 0;
        if (it.is_end) begin
            if (pend_state == PEND_LEAD || pend_state == PEND_SECOND) emit(CH_QMARK);
            pend_state  = PEND_NONE;
            lead_byte   = 8'd0;
            second_byte = 8'd0;
            emit(CH_NUL);
        end else if (pend_state == PEND_LEAD) begin
            if (b >= CONT_MIN && b <= CONT_MAX) begin
                if (lead_byte < LEAD_3B_MIN) begin
                    v = ({24'd0, lead_byte} - {24'd0, LEAD_MIN}) * 32'd64 + {24'd0, b};
                    emit_ref(v, (lead_byte > LEAD_2DIG_MAX) ? 3 : 2);
                    pend_state = PEND_NONE;
                end else begin
                    second_byte = b;
                    pend_state  = PEND_SECOND;
                end
            end else begin
                emit(CH_QMARK);
                pend_state = PEND_NONE;
                plain_byte(b);
            end
        end else if (pend_state == PEND_SECOND) begin
            // The third byte is taken as it comes; the sum wraps at 32 bits.
            v = ({24'd0, lead_byte} - {24'd0, LEAD_3B_MIN}) * 32'd4096
                + ({24'd0, second_byte} - {24'd0, CONT_MIN}) * 32'd64
                + {24'd0, b} - {24'd0, CONT_MIN};
            emit_ref(v, (lead_byte > LEAD_3B_MIN) ? 4 : 3);
            pend_state = PEND_NONE;
        end else begin
            pend_state = PEND_NONE;
            plain_byte(b);
        end
    endtask

    task automatic push_run();
        int i;
        out_item_t c;
        for (i = 0; i < run_len; i++) begin
            c.out_char = run_buf[i];
            c.run_last = (i == run_len - 1);
            expected_chars.push_back(c);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0) begin
            s_valid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        s_valid = 1'b1;
        s_data  = it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic feed(input logic [7:0] b, input logic e);
        in_item_t it;
        it.in_byte = b;
        it.is_end  = e;
        predict_escape(it);
        push_run();
        send_item(it);
    endtask

    // The mode is only changed once every predicted character has come out.
    task automatic set_mode(input logic v);
        s_valid = 1'b0;
        while (expected_chars.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        uni_mode  = v;
        mode_writes++;
    endtask

    task automatic add_item(input logic [7:0] b, input logic e, input logic typed,
                            input string text);
        in_item_t it;
        it.in_byte = b;
        it.is_end  = e;
        row_kind.push_back(ROW_ITEM);
        row_item.push_back(it);
        row_typed.push_back(typed);
        row_text.push_back(text);
        row_mode.push_back(1'b0);
    endtask

    task automatic add_mode(input logic v);
        row_kind.push_back(ROW_MODE);
        row_item.push_back('0);
        row_typed.push_back(1'b0);
        row_text.push_back("");
        row_mode.push_back(v);
    endtask

    task automatic random_phase(input int count);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // Well-formed sequences with random content; the third byte is
                // sometimes arbitrary since the block does not check it.
                if ($urandom_range(0, 1)) begin
                    feed(rand_byte(194, 223), 1'b0);
                    feed(rand_byte(CONT_MIN, CONT_MAX), 1'b0);
                end else begin
                    feed(rand_byte(224, 255), 1'b0);
                    feed(rand_byte(CONT_MIN, CONT_MAX), 1'b0);
                    feed(($urandom_range(0, 3) == 0) ? rand_byte(0, 255)
                                                     : rand_byte(CONT_MIN, CONT_MAX), 1'b0);
                end
            end else if (pick < 60) begin
                feed(rand_byte(32, 126), 1'b0);
            end else if (pick < 70) begin
                case ($urandom_range(0, 3))
                    0:       feed(CH_GT, 1'b0);
                    1:       feed(CH_LT, 1'b0);
                    2:       feed(CH_AMP, 1'b0);
                    default: feed(CH_QUOT, 1'b0);
                endcase
            end else if (pick < 80) begin
                feed(rand_byte(0, 255), 1'b0);
            end else if (pick < 88) begin
                feed(rand_byte(194, 255), 1'b0);
                feed($urandom_range(0, 1) ? rand_byte(0, 127) : rand_byte(192, 255), 1'b0);
            end else if (pick < 94) begin
                feed(rand_byte(194, 255), 1'b0);
                if ($urandom_range(0, 1)) feed(rand_byte(CONT_MIN, CONT_MAX), 1'b0);
                feed(rand_byte(0, 255), 1'b1);
            end else begin
                feed(rand_byte(0, 255), 1'b1);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                $display("%0t: output with nothing expected: out_char %h run_last %b",
                         $time, m_data.out_char, m_data.run_last);
                errors++;
            end else begin
                want = expected_chars.pop_front();
                if (m_data.out_char !== want.out_char) begin
                    $display("%0t: out_char expected %h got %h", $time,
                             want.out_char, m_data.out_char);
                    errors++;
                end
                if (m_data.run_last !== want.run_last) begin
                    $display("%0t: run_last expected %b got %b", $time,
                             want.run_last, m_data.run_last);
                    errors++;
                end
            end
        end
    end

    // Output side: stretches of random stall density, plus one long hold-off on request.
    initial begin : receiver
        int stretch;
        int stall_pct;
        int hold_left;
        logic hold_done;
        m_ready   = 1'b0;
        stretch   = 0;
        stall_pct = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                if (stretch == 0) begin
                    stretch = $urandom_range(4, 40);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                stretch--;
                m_ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int r;
        int k;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        hold_request = 1'b0;
        uni_mode     = 1'b1;
        lead_byte    = 8'd0;
        second_byte  = 8'd0;
        pend_state   = PEND_NONE;
        items_sent     = 0;
        refs_predicted = 0;
        mode_writes    = 0;
        burst_left     = 0;

        add_item(8'h41, 1'b0, 1'b1, "A");
        add_item(CH_GT,   1'b0, 1'b1, "&gt;");
        add_item(CH_LT,   1'b0, 1'b1, "&lt;");
        add_item(CH_AMP,  1'b0, 1'b1, "&amp;");
        add_item(CH_QUOT, 1'b0, 1'b1, "&quot;");
        add_item(8'h00, 1'b0, 1'b0, "");        // zero byte passes, string goes on
        add_item(8'hC2, 1'b0, 1'b1, "");        // held after reset: mode starts at 1
        add_item(8'h80, 1'b0, 1'b1, "&#x80;");
        add_item(8'hDF, 1'b0, 1'b0, "");
        add_item(8'hBF, 1'b0, 1'b0, "");
        add_item(8'hE0, 1'b0, 1'b0, "");
        add_item(8'h80, 1'b0, 1'b0, "");
        add_item(8'h80, 1'b0, 1'b0, "");
        add_item(8'hFF, 1'b0, 1'b0, "");        // largest three-byte value wraps
        add_item(8'hBF, 1'b0, 1'b0, "");
        add_item(8'hFF, 1'b0, 1'b0, "");
        add_item(8'hC8, 1'b0, 1'b1, "");
        add_item(8'h41, 1'b0, 1'b1, "?A");
        add_item(8'hC8, 1'b0, 1'b1, "");
        add_item(8'hF0, 1'b0, 1'b1, "?");       // bad continuation that is held itself
        add_item(8'h80, 1'b0, 1'b1, "");
        add_item(8'hAA, 1'b1, 1'b1, "?");       // cut off with two bytes held
        add_item(8'hC5, 1'b0, 1'b1, "");
        add_mode(1'b0);                          // the held lead still completes
        add_item(8'hA9, 1'b0, 1'b0, "");
        add_item(8'hFF, 1'b0, 1'b0, "");
        add_item(CH_AMP, 1'b0, 1'b1, "&amp;");
        add_mode(1'b1);

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        for (r = 0; r < row_kind.size(); r++) begin
            if (row_kind[r] == ROW_MODE) begin
                set_mode(row_mode[r]);
            end else begin
                predict_escape(row_item[r]);
                if (row_typed[r]) begin
                    run_len = 0;
                    for (k = 0; k < row_text[r].len(); k++) emit(row_text[r][k]);
                    if (row_item[r].is_end) emit(CH_NUL);
                end
                push_run();
                send_item(row_item[r]);
            end
        end

        hold_request = 1'b1;
        random_phase(PHASE_ITEMS);
        set_mode(1'b0);
        random_phase(PHASE_ITEMS);
        set_mode(1'b1);
        random_phase(PHASE_ITEMS);
        set_mode(1'($urandom_range(0, 1)));
        random_phase(PHASE_ITEMS);
        set_mode(1'b1);
        random_phase(PHASE_ITEMS);

        s_valid = 1'b0;
        while (expected_chars.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d requests (%0d table rows), checked %0d output characters,",
                 items_sent, row_kind.size(), chars_checked);
        $display("%0d hex refs; unicode_mode written %0d times; %0d mismatches seen.",
                 refs_predicted, mode_writes, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/hee_pkg.sv
design/hee_encode.sv
design/html_entity_escape_stream.sv
bench/tb.sv
